>>> sv/lens_undistort_source_address_top_macros.svh
// Assertion macros for the lens undistortion source address block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef LENS_UNDISTORT_SOURCE_ADDRESS_TOP_MACROS_SVH
`define LENS_UNDISTORT_SOURCE_ADDRESS_TOP_MACROS_SVH

// same-cycle implication, off while reset is high
`define LUSA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define LUSA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset too
`define LUSA_ASSERT_RAW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lusa_pkg.sv
// Shared types, register codes and fixed-point helpers for the lens remap block.
// No dependencies.
package lusa_pkg;

   localparam int FRAC       = 28;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOCAL_X  = 4'd0,
      REG_FOCAL_Y  = 4'd1,
      REG_CENTRE_X = 4'd2,
      REG_CENTRE_Y = 4'd3,
      REG_RADIAL_K1 = 4'd4,
      REG_RADIAL_K2 = 4'd5,
      REG_TAN_P1   = 4'd6,
      REG_TAN_P2   = 4'd7
   } csr_reg_type;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;

   typedef struct packed {
      logic [9:0] out_col;
      logic [9:0] out_row;
   } req_type;

   typedef struct packed {
      logic [9:0] src_col;
      logic [9:0] src_row;
      logic       inside_res;
   } rsp_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [19:0] rem;
      logic [31:0] quot;
      logic [3:0]  low4;
      logic        neg;
      logic        ovf;
   } div_type;

   function automatic logic signed [31:0] sat_q(input logic signed [65:0] v);
      if (v > 66'sh7FFF_FFFF) begin
         return Q_MAX;
      end else if (v < -66'sh8000_0000) begin
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   // full product back to Q4.28, floor rounding, saturated
   function automatic logic signed [31:0] q_mul(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p >>> FRAC;
      return sat_q(66'(t));
   endfunction

   // four quotient bits of the restoring divider
   function automatic div_type div4(input div_type s, input logic [19:0] f);
      div_type    o;
      logic [20:0] r;
      logic        qb;
      o = s;
      for (int i = 0; i < 4; i++) begin
         r  = {o.rem, o.low4[3]};
         qb = (r >= {1'b0, f});
         if (qb) begin
            r = r - {1'b0, f};
         end
         o.rem  = r[19:0];
         o.quot = {o.quot[30:0], qb};
         o.low4 = {o.low4[2:0], 1'b0};
      end
      return o;
   endfunction

   // signed, saturated Q4.28 from the magnitude quotient
   function automatic logic signed [31:0] norm_q(input div_type s);
      if (s.ovf) begin
         return s.neg ? Q_MIN : Q_MAX;
      end else if (!s.neg) begin
         return s.quot[31] ? Q_MAX : $signed(s.quot);
      end
      return s.quot[31] ? Q_MIN : -$signed(s.quot);
   endfunction

endpackage

>>> sv/lens_undistort_source_address_top.sv
// Lens undistortion source address: Brown-Conrady remap as a 21-stage pipeline.
// Depends on lusa_pkg.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | lusa_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | lusa_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One item per cycle while no result is held. The normalizing
// divider sets the depth: eight stages of four quotient bits each.
// A stalled result freezes the whole pipeline; req_stall follows rsp_stall
// only while a result is held. Synchronous reset clears valid bits and loads
// the calibration registers; csr_ready is always high.
module lens_undistort_source_address_top #(
   parameter int IMG_WIDTH  = 1024,
   parameter int IMG_HEIGHT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lusa_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lusa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lusa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lusa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lusa_pkg::*;

   localparam int NST   = 21;
   localparam int NDIV  = 8;
   localparam logic signed [26:0] U_LIM = 27'(IMG_WIDTH * 256);
   localparam logic signed [26:0] V_LIM = 27'(IMG_HEIGHT * 256);

   // calibration registers
   logic [19:0]        focal_x_ff, focal_y_ff, centre_x_ff, centre_y_ff;
   logic signed [31:0] k1_ff, k2_ff, p1_ff, p2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 20'd117415;
         focal_y_ff  <= 20'd117068;
         centre_x_ff <= 20'd94007;
         centre_y_ff <= 20'd63584;
         k1_ff       <= -32'sd76076786;
         k2_ff       <= 32'sd19853237;
         p1_ff       <= 32'sd51966;
         p2_ff       <= 32'sd4729;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FOCAL_X:   focal_x_ff  <= csr_wdata[19:0];
            REG_FOCAL_Y:   focal_y_ff  <= csr_wdata[19:0];
            REG_CENTRE_X:  centre_x_ff <= csr_wdata[19:0];
            REG_CENTRE_Y:  centre_y_ff <= csr_wdata[19:0];
            REG_RADIAL_K1: k1_ff       <= $signed(csr_wdata);
            REG_RADIAL_K2: k2_ff       <= $signed(csr_wdata);
            REG_TAN_P1:    p1_ff       <= $signed(csr_wdata);
            REG_TAN_P2:    p2_ff       <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // pipeline control
   logic           en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[NST-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NST-1];
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // normalizing dividers: prep stage, then NDIV stages of four bits
   logic [19:0]        fx_eff, fy_eff;
   logic signed [21:0] dx, dy;
   logic [20:0]        ax, ay;
   div_type            divx_ff [0:NDIV];
   div_type            divy_ff [0:NDIV];
   div_type            divx_in [0:NDIV];
   div_type            divy_in [0:NDIV];

   always_comb begin
      // zero focal length divides as one LSB
      fx_eff = (focal_x_ff == '0) ? 20'd1 : focal_x_ff;
      fy_eff = (focal_y_ff == '0) ? 20'd1 : focal_y_ff;
      dx = $signed({4'b0, req_data.out_col, 8'b0}) - $signed({2'b0, centre_x_ff});
      dy = $signed({4'b0, req_data.out_row, 8'b0}) - $signed({2'b0, centre_y_ff});
      ax = dx[21] ? 21'(-dx) : dx[20:0];
      ay = dy[21] ? 21'(-dy) : dy[20:0];
      // quotient needs 33 bits or more exactly when |d| >= 16*f
      divx_in[0] = '{rem: 20'(ax[20:4]), quot: '0, low4: ax[3:0], neg: dx[21],
                     ovf: ({3'b0, ax} >= {fx_eff, 4'b0})};
      divy_in[0] = '{rem: 20'(ay[20:4]), quot: '0, low4: ay[3:0], neg: dy[21],
                     ovf: ({3'b0, ay} >= {fy_eff, 4'b0})};
      for (int g = 1; g <= NDIV; g++) begin
         divx_in[g] = div4(divx_ff[g-1], fx_eff);
         divy_in[g] = div4(divy_ff[g-1], fy_eff);
      end
   end

   // datapath stages
   logic signed [31:0] x_n_ff, y_n_ff;
   logic signed [63:0] px2_a_ff, py2_a_ff, pxy_a_ff;
   logic signed [31:0] x_a_ff, y_a_ff;
   logic signed [31:0] xx_b_ff, yy_b_ff, xy_b_ff, x_b_ff, y_b_ff;
   logic signed [31:0] r2_c_ff, xx_c_ff, yy_c_ff, xy_c_ff, x_c_ff, y_c_ff;
   logic signed [63:0] prr_d_ff, pk1_d_ff, pp1xy_d_ff, pp2xy_d_ff;
   logic signed [31:0] sx_d_ff, sy_d_ff, x_d_ff, y_d_ff;
   logic signed [31:0] r4_e_ff, k1r2_e_ff, tx1_e_ff, ty2_e_ff;
   logic signed [31:0] sx_e_ff, sy_e_ff, x_e_ff, y_e_ff;
   logic signed [63:0] pk2_f_ff, pp2sx_f_ff, pp1sy_f_ff;
   logic signed [31:0] k1r2_f_ff, tx1_f_ff, ty2_f_ff, x_f_ff, y_f_ff;
   logic signed [31:0] fac_g_ff, tx2_g_ff, ty1_g_ff, tx1_g_ff, ty2_g_ff;
   logic signed [31:0] x_g_ff, y_g_ff;
   logic signed [63:0] pxf_h_ff, pyf_h_ff;
   logic signed [31:0] tx1_h_ff, tx2_h_ff, ty1_h_ff, ty2_h_ff;
   logic signed [31:0] xdist_i_ff, ydist_i_ff;
   logic signed [52:0] pu_j_ff, pv_j_ff;
   rsp_type            rsp_ff, rsp_in;

   logic signed [26:0] ud, vd;
   logic               in_frame;

   always_comb begin
      ud = 27'(pu_j_ff >>> FRAC) + $signed({7'b0, centre_x_ff});
      vd = 27'(pv_j_ff >>> FRAC) + $signed({7'b0, centre_y_ff});
      in_frame = !ud[26] && !vd[26] && (ud < U_LIM) && (vd < V_LIM);
      rsp_in.src_col    = in_frame ? ud[17:8] : '0;
      rsp_in.src_row    = in_frame ? vd[17:8] : '0;
      rsp_in.inside_res = in_frame;
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g <= NDIV; g++) begin
            divx_ff[g] <= divx_in[g];
            divy_ff[g] <= divy_in[g];
         end
         x_n_ff <= norm_q(divx_ff[NDIV]);
         y_n_ff <= norm_q(divy_ff[NDIV]);

         px2_a_ff <= x_n_ff * x_n_ff;
         py2_a_ff <= y_n_ff * y_n_ff;
         pxy_a_ff <= x_n_ff * y_n_ff;
         x_a_ff   <= x_n_ff;
         y_a_ff   <= y_n_ff;

         xx_b_ff <= q_mul(px2_a_ff);
         yy_b_ff <= q_mul(py2_a_ff);
         xy_b_ff <= q_mul(pxy_a_ff);
         x_b_ff  <= x_a_ff;
         y_b_ff  <= y_a_ff;

         r2_c_ff <= sat_q(66'(xx_b_ff) + 66'(yy_b_ff));
         xx_c_ff <= xx_b_ff;
         yy_c_ff <= yy_b_ff;
         xy_c_ff <= xy_b_ff;
         x_c_ff  <= x_b_ff;
         y_c_ff  <= y_b_ff;

         prr_d_ff   <= r2_c_ff * r2_c_ff;
         pk1_d_ff   <= k1_ff * r2_c_ff;
         pp1xy_d_ff <= p1_ff * xy_c_ff;
         pp2xy_d_ff <= p2_ff * xy_c_ff;
         sx_d_ff    <= sat_q(66'(r2_c_ff) + (66'(xx_c_ff) <<< 1));
         sy_d_ff    <= sat_q(66'(r2_c_ff) + (66'(yy_c_ff) <<< 1));
         x_d_ff     <= x_c_ff;
         y_d_ff     <= y_c_ff;

         r4_e_ff   <= q_mul(prr_d_ff);
         k1r2_e_ff <= q_mul(pk1_d_ff);
         tx1_e_ff  <= sat_q(66'(q_mul(pp1xy_d_ff)) <<< 1);
         ty2_e_ff  <= sat_q(66'(q_mul(pp2xy_d_ff)) <<< 1);
         sx_e_ff   <= sx_d_ff;
         sy_e_ff   <= sy_d_ff;
         x_e_ff    <= x_d_ff;
         y_e_ff    <= y_d_ff;

         pk2_f_ff   <= k2_ff * r4_e_ff;
         pp2sx_f_ff <= p2_ff * sx_e_ff;
         pp1sy_f_ff <= p1_ff * sy_e_ff;
         k1r2_f_ff  <= k1r2_e_ff;
         tx1_f_ff   <= tx1_e_ff;
         ty2_f_ff   <= ty2_e_ff;
         x_f_ff     <= x_e_ff;
         y_f_ff     <= y_e_ff;

         // radial factor summed at full width, saturated once
         fac_g_ff <= sat_q(66'(Q_ONE) + 66'(k1r2_f_ff) + 66'(q_mul(pk2_f_ff)));
         tx2_g_ff <= q_mul(pp2sx_f_ff);
         ty1_g_ff <= q_mul(pp1sy_f_ff);
         tx1_g_ff <= tx1_f_ff;
         ty2_g_ff <= ty2_f_ff;
         x_g_ff   <= x_f_ff;
         y_g_ff   <= y_f_ff;

         pxf_h_ff <= x_g_ff * fac_g_ff;
         pyf_h_ff <= y_g_ff * fac_g_ff;
         tx1_h_ff <= tx1_g_ff;
         tx2_h_ff <= tx2_g_ff;
         ty1_h_ff <= ty1_g_ff;
         ty2_h_ff <= ty2_g_ff;

         xdist_i_ff <= sat_q(66'(q_mul(pxf_h_ff)) + 66'(tx1_h_ff) + 66'(tx2_h_ff));
         ydist_i_ff <= sat_q(66'(q_mul(pyf_h_ff)) + 66'(ty1_h_ff) + 66'(ty2_h_ff));

         pu_j_ff <= $signed({1'b0, focal_x_ff}) * xdist_i_ff;
         pv_j_ff <= $signed({1'b0, focal_y_ff}) * ydist_i_ff;

         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/lusa_checker.sv
// Port-level checks for the lens remap top level, bound to every instance.
// Depends on lusa_pkg and lens_undistort_source_address_top_macros.svh.
`include "lens_undistort_source_address_top_macros.svh"

module lusa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lusa_pkg::rsp_type rsp_data
);
   import lusa_pkg::*;

   // an outside point carries a zero address
   `LUSA_ASSERT_IMP(a_outside_zero, rsp_valid && !rsp_data.inside_res, rsp_data.src_col == '0 && rsp_data.src_row == '0, "outside item with nonzero address")

   // input is held back only by a held result
   `LUSA_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without output stall")

   // a held result stays put
   `LUSA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled item changed")

   // reset drops every item in flight
   `LUSA_ASSERT_RAW(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind lens_undistort_source_address_top lusa_checker u_lusa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/testbench.sv
// Self-checking testbench for the lens undistortion source address block.
// Depends on lusa_pkg and lens_undistort_source_address_top.
`timescale 1ns / 1ps

module testbench;
   import lusa_pkg::*;

   localparam int IMG_W = 1024;
   localparam int IMG_H = 1024;
   localparam int PIPE_DEPTH = 21;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lens_undistort_source_address_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // calibration copy
   logic [19:0] cal_fx, cal_fy, cal_cx, cal_cy;
   longint cal_k1, cal_k2, cal_p1, cal_p2;

   rsp_type addr_queue[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int inside_seen = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycles = 0;

   function automatic longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_q(longint a, longint b);
      return clamp_q((a * b) >>> 28);
   endfunction

   function automatic longint to_norm(longint pix, longint ctr, longint foc);
      longint d;
      longint div;
      longint num;
      d = pix * 256 - ctr;
      div = (foc == 0) ? 1 : foc;
      num = d * (64'sd1 << 28);
      // SV division truncates toward zero
      return clamp_q(num / div);
   endfunction

   function automatic rsp_type source_address(req_type r);
      longint x, y, xx, yy, r2, r4, xy, fac, sx, sy, tx1, tx2, ty1, ty2, xd, yd;
      longint ud, vd;
      rsp_type o;
      x = to_norm(longint'(r.out_col), longint'(cal_cx), longint'(cal_fx));
      y = to_norm(longint'(r.out_row), longint'(cal_cy), longint'(cal_fy));
      xx = floor_q(x, x);
      yy = floor_q(y, y);
      r2 = clamp_q(xx + yy);
      r4 = floor_q(r2, r2);
      xy = floor_q(x, y);
      fac = clamp_q((64'sd1 << 28) + floor_q(cal_k1, r2) + floor_q(cal_k2, r4));
      sx = clamp_q(r2 + 2 * xx);
      sy = clamp_q(r2 + 2 * yy);
      tx1 = clamp_q(2 * floor_q(cal_p1, xy));
      tx2 = floor_q(cal_p2, sx);
      ty1 = floor_q(cal_p1, sy);
      ty2 = clamp_q(2 * floor_q(cal_p2, xy));
      xd = clamp_q(floor_q(x, fac) + tx1 + tx2);
      yd = clamp_q(floor_q(y, fac) + ty1 + ty2);
      ud = ((longint'(cal_fx) * xd) >>> 28) + longint'(cal_cx);
      vd = ((longint'(cal_fy) * yd) >>> 28) + longint'(cal_cy);
      o = '0;
      if (ud >= 0 && vd >= 0 && ud < IMG_W * 256 && vd < IMG_H * 256) begin
         o.src_col = ud[17:8];
         o.src_row = vd[17:8];
         o.inside_res = 1'b1;
      end
      return o;
   endfunction

   task automatic report(string what, rsp_type got, rsp_type want);
      errors++;
      $display("MISMATCH %s: got col %0d row %0d in %0b, want col %0d row %0d in %0b",
               what, got.src_col, got.src_row, got.inside_res,
               want.src_col, want.src_row, want.inside_res);
   endtask

   // cycle counter, timeout, receiver stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: done, errors");
         $finish;
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (addr_queue.size() == 0) begin
            report("unexpected item", rsp_data, '0);
         end else begin
            want = addr_queue.pop_front();
            if (rsp_data.src_col !== want.src_col) report("src_col", rsp_data, want);
            if (rsp_data.src_row !== want.src_row) report("src_row", rsp_data, want);
            if (rsp_data.inside_res !== want.inside_res)
               report("inside_res", rsp_data, want);
            if (want.inside_res) inside_seen++;
         end
         checked++;
      end
   end

   // leaves req_valid high; drain or an idle gap before the next item takes it down
   task automatic send_pixel(logic [9:0] col, logic [9:0] row);
      req_type r;
      r.out_col = col;
      r.out_row = row;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      addr_queue.push_back(source_address(r));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (addr_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // leaves csr_valid high; load_cal drops it after the last write
   task automatic write_reg(csr_reg_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FOCAL_X: cal_fx = val[19:0];
         REG_FOCAL_Y: cal_fy = val[19:0];
         REG_CENTRE_X: cal_cx = val[19:0];
         REG_CENTRE_Y: cal_cy = val[19:0];
         REG_RADIAL_K1: cal_k1 = longint'($signed(val));
         REG_RADIAL_K2: cal_k2 = longint'($signed(val));
         REG_TAN_P1: cal_p1 = longint'($signed(val));
         default: cal_p2 = longint'($signed(val));
      endcase
   endtask

   task automatic load_cal(logic [19:0] fx, logic [19:0] fy, logic [19:0] cx,
                           logic [19:0] cy, logic [31:0] k1, logic [31:0] k2,
                           logic [31:0] p1, logic [31:0] p2);
      write_reg(REG_FOCAL_X, {12'hABC, fx});
      write_reg(REG_FOCAL_Y, {12'h543, fy});
      write_reg(REG_CENTRE_X, {12'hFFF, cx});
      write_reg(REG_CENTRE_Y, {12'h000, cy});
      write_reg(REG_RADIAL_K1, k1);
      write_reg(REG_RADIAL_K2, k2);
      write_reg(REG_TAN_P1, p1);
      write_reg(REG_TAN_P2, p2);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_calibration();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd367, 10'd248);
      send_pixel(10'h2AA, 10'h155);
      send_pixel(10'h155, 10'h2AA);
      drain();
   endtask

   task automatic test_corner_cases();
      // out-of-range index goes nowhere
      csr_valid <= 1'b1;
      csr_index <= 4'd12;
      csr_wdata <= 32'h0;
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      // zero focal lengths saturate the normalized point
      load_cal(20'd0, 20'd0, 20'd94007, 20'd63584, 32'h0, 32'h0, 32'h0, 32'h0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd367, 10'd248);
      drain();
      // extreme coefficients and centres
      load_cal(20'hFFFFF, 20'd256, 20'hFFFFF, 20'd0, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd3);
      drain();
      load_cal(20'd256, 20'hFFFFF, 20'd0, 20'hFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 32'h7FFFFFFF);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd1, 10'd1022);
      drain();
      // identity mapping: every pixel maps to itself
      load_cal(20'd131072, 20'd131072, 20'd131072, 20'd131072, 32'h0, 32'h0,
               32'h0, 32'h0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd700, 10'd20);
      drain();
   endtask

   task automatic test_random_remap(int n);
      int mode;
      mode = $urandom_range(3);
      case (mode)
         0: load_cal(20'd117415, 20'd117068, 20'd94007, 20'd63584, 32'hFB772F0E,
                     32'h012EEFB5, 32'd51966, 32'd4729);
         1: load_cal(20'($urandom_range(1048575, 256)), 20'($urandom_range(1048575, 256)),
                     20'($urandom), 20'($urandom), $urandom, $urandom, $urandom,
                     $urandom);
         default: load_cal(20'($urandom_range(300000, 60000)),
                           20'($urandom_range(300000, 60000)),
                           20'($urandom_range(200000, 60000)),
                           20'($urandom_range(200000, 60000)),
                           32'($signed($urandom_range(100000000)) - 50000000),
                           32'($signed($urandom_range(40000000)) - 20000000),
                           32'($signed($urandom_range(200000)) - 100000),
                           32'($signed($urandom_range(200000)) - 100000));
      endcase
      for (int i = 0; i < n; i++) begin
         send_pixel(10'($urandom), 10'($urandom));
      end
      drain();
   endtask

   initial begin
      cal_fx = 20'd117415;
      cal_fy = 20'd117068;
      cal_cx = 20'd94007;
      cal_cy = 20'd63584;
      cal_k1 = -76076786;
      cal_k2 = 19853237;
      cal_p1 = 51966;
      cal_p2 = 4729;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_corner_cases();
      send_idle_pct = 6;
      recv_stall_pct = 64;
      for (int p = 0; p < 6; p++) test_random_remap(58);
      send_idle_pct = 64;
      recv_stall_pct = 6;
      for (int p = 0; p < 6; p++) test_random_remap(58);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int p = 0; p < 6; p++) test_random_remap(58);
      drain();
      $display("sent %0d pixel coordinates over 22 calibrations, checked %0d addresses",
               sent, checked);
      $display("%0d of them landed inside the frame", inside_seen);
      if (errors == 0 && addr_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+sv
sv/lusa_pkg.sv
sv/lens_undistort_source_address_top.sv
sv/lusa_checker.sv
tb/testbench.sv
